// ===== src/cpr_pkg.sv =====
// Shared types and constants for the CAN packet reassembler.
// No dependencies; imported by every module of the block except cpr_queue.
`default_nettype none

package cpr_pkg;

    // control byte fields
    localparam logic [7:0] CTL_START = 8'h80;
    localparam logic [7:0] CTL_END   = 8'h40;
    localparam logic [7:0] CTL_SEQ   = 8'h0F;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd500;
    localparam logic [3:0]  DLC_MAX         = 4'd8;
    localparam int          PAY_BYTES       = 7;

    // configuration register indexes
    localparam logic CFG_HOST_ID = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STORED   = 3'd1,
        EV_COMPLETE = 3'd2,
        EV_DROP     = 3'd3,
        EV_TIMEOUT  = 3'd4
    } t_event;

    // what the front end made of one beat
    typedef enum logic [2:0] {
        K_IGNORE,
        K_TICK,
        K_START_SHORT,
        K_START_BADLEN,
        K_START,
        K_CONT
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic [3:0]                     seq;
        logic                           end_flag;
        logic [15:0]                    len;
        logic [2:0]                     cnt;
        logic [PAY_BYTES-1:0][7:0]      pay;
    } t_cmd;

    typedef struct packed {
        t_event                         ev;
        logic [10:0]                    offset;
        logic [2:0]                     cnt;
        logic [PAY_BYTES-1:0][7:0]      pay;
        logic [11:0]                    pkt_len;
        logic [31:0]                    drops;
    } t_result;

    typedef struct packed {
        logic        load;
        logic        busy;
        logic [31:0] drop_cnt;
    } t_back_status;

endpackage

`default_nettype wire

// ===== src/cpr_front.sv =====
// Front end: decodes one input beat into a command for the back end.
// Stateless apart from the host_id register it is given. Uses cpr_pkg.
`default_nettype none

module cpr_front #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  wire logic                i_mode,
    input  wire logic [28:0]         i_frame_id,
    input  wire logic                i_extended,
    input  wire logic [3:0]          i_dlc,
    input  wire logic [7:0][7:0]     i_data,
    input  wire logic [28:0]         i_host_id,
    output cpr_pkg::t_cmd            o_cmd
);
    import cpr_pkg::*;

    logic [3:0]             w_dlc;
    logic [3:0]             w_d3;
    logic [15:0]            w_len;
    logic                   w_for_us;
    logic                   w_start;
    logic [2:0]             w_cnt;
    logic [PAY_BYTES-1:0][7:0] w_src;

    always_comb begin
        w_dlc    = (i_dlc > DLC_MAX) ? DLC_MAX : i_dlc;
        w_for_us = (i_frame_id == i_host_id) && !i_extended && (w_dlc != 4'd0);
        w_start  = (i_data[0] & CTL_START) != 8'h00;
        w_len    = {i_data[2], i_data[1]};
        w_d3     = w_dlc - 4'd3;

        o_cmd          = '0;
        o_cmd.seq      = i_data[0][3:0] & CTL_SEQ[3:0];
        o_cmd.end_flag = (i_data[0] & CTL_END) != 8'h00;
        o_cmd.len      = w_len;

        if (w_start) begin
            // start frame: payload begins after the length bytes
            w_cnt = ({12'd0, w_d3} > w_len) ? w_len[2:0] : w_d3[2:0];
            for (int k = 0; k < PAY_BYTES; k++) begin
                w_src[k] = (k + 3 < 8) ? i_data[(k + 3) % 8] : 8'h00;
            end
        end else begin
            w_cnt = 3'(w_dlc - 4'd1);
            for (int k = 0; k < PAY_BYTES; k++) begin
                w_src[k] = i_data[k + 1];
            end
        end
        o_cmd.cnt = w_cnt;
        for (int k = 0; k < PAY_BYTES; k++) begin
            o_cmd.pay[k] = (3'(k) < w_cnt) ? w_src[k] : 8'h00;
        end

        if (i_mode) begin
            o_cmd.kind = K_TICK;
        end else if (!w_for_us) begin
            o_cmd.kind = K_IGNORE;
        end else if (w_start) begin
            if (w_dlc < 4'd3) begin
                o_cmd.kind = K_START_SHORT;
            end else if (w_len == 16'd0 || {1'b0, w_len} > 17'(MAX_PACKET_BYTES)) begin
                o_cmd.kind = K_START_BADLEN;
            end else begin
                o_cmd.kind = K_START;
            end
        end else begin
            o_cmd.kind = K_CONT;
        end
    end

endmodule

`default_nettype wire

// ===== src/cpr_queue.sv =====
// Small register FIFO between the front and back ends.
// Generic width and depth; no package dependency.
`default_nettype none

module cpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/cpr_back.sv =====
// Back end: applies commands to the reassembly state and registers results.
// Holds length, count, sequence, idle ticks and drop counter. Uses cpr_pkg.
`default_nettype none

module cpr_back #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [15:0]       i_timeout,
    input  wire logic              i_valid,
    input  cpr_pkg::t_cmd          i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cpr_pkg::t_result       o_res,
    output cpr_pkg::t_back_status  o_status
);
    import cpr_pkg::*;

    localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [LEN_W-1:0] r_exp, n_exp;
    logic [LEN_W-1:0] r_rcv, n_rcv;
    logic [3:0]       r_seq, n_seq;
    logic [15:0]      r_idle, n_idle;
    logic [31:0]      r_drops, n_drops;
    logic             r_out_valid;
    t_result          r_res, n_res;

    logic             w_load;
    logic             w_drop;
    logic [LEN_W:0]   w_sum;
    logic [15:0]      w_idle_inc;
    logic [31:0]      w_rcv32, w_exp32;

    assign w_load   = i_valid && (!r_out_valid || i_ready);
    assign o_pop    = w_load;
    assign o_valid  = r_out_valid;
    assign o_res    = r_res;
    assign o_status = '{load: w_load, busy: (r_exp != '0), drop_cnt: r_drops};

    always_comb begin
        n_exp   = r_exp;
        n_rcv   = r_rcv;
        n_seq   = r_seq;
        n_idle  = r_idle;
        n_res   = '0;
        w_drop  = 1'b0;
        w_sum   = {1'b0, r_rcv} + (LEN_W + 1)'(i_cmd.cnt);
        w_idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
        w_rcv32 = 32'(r_rcv);
        w_exp32 = 32'(r_exp);
        n_res.ev = EV_NONE;

        case (i_cmd.kind)
            K_TICK: begin
                if (r_exp != '0) begin
                    n_idle = w_idle_inc;
                    if (w_idle_inc > i_timeout) begin
                        n_exp    = '0;
                        w_drop   = 1'b1;
                        n_res.ev = EV_TIMEOUT;
                    end
                end
            end
            K_START_SHORT: begin
                // packet in progress survives
                w_drop   = 1'b1;
                n_res.ev = EV_DROP;
            end
            K_START_BADLEN: begin
                n_exp    = '0;
                w_drop   = 1'b1;
                n_res.ev = EV_DROP;
            end
            K_START: begin
                n_exp     = LEN_W'(i_cmd.len);
                n_rcv     = LEN_W'(i_cmd.cnt);
                n_seq     = i_cmd.seq + 4'd1;
                n_idle    = '0;
                n_res.ev  = EV_STORED;
                n_res.cnt = i_cmd.cnt;
                n_res.pay = i_cmd.pay;
                if (i_cmd.end_flag && (16'(i_cmd.cnt) == i_cmd.len)) begin
                    n_res.ev      = EV_COMPLETE;
                    n_res.pkt_len = i_cmd.len[11:0];
                    n_exp         = '0;
                end
            end
            K_CONT: begin
                if (r_exp == '0 || i_cmd.seq != r_seq) begin
                    n_exp    = '0;
                    w_drop   = 1'b1;
                    n_res.ev = EV_DROP;
                end else if (w_sum > {1'b0, r_exp}) begin
                    // would overrun the announced length
                    n_exp    = '0;
                    w_drop   = 1'b1;
                    n_res.ev = EV_DROP;
                end else begin
                    n_rcv        = w_sum[LEN_W-1:0];
                    n_seq        = i_cmd.seq + 4'd1;
                    n_idle       = '0;
                    n_res.ev     = EV_STORED;
                    n_res.offset = w_rcv32[10:0];
                    n_res.cnt    = i_cmd.cnt;
                    n_res.pay    = i_cmd.pay;
                    if (i_cmd.end_flag && (w_sum == {1'b0, r_exp})) begin
                        n_res.ev      = EV_COMPLETE;
                        n_res.pkt_len = w_exp32[11:0];
                        n_exp         = '0;
                    end
                end
            end
            default: begin
                n_res.ev = EV_NONE;
            end
        endcase

        n_drops     = w_drop ? r_drops + 32'd1 : r_drops;
        n_res.drops = n_drops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_rcv       <= '0;
            r_seq       <= '0;
            r_idle      <= '0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_exp   <= n_exp;
                r_rcv   <= n_rcv;
                r_seq   <= n_seq;
                r_idle  <= n_idle;
                r_drops <= n_drops;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== src/can_packet_reassembler_unit.sv =====
// Channel   Dir  Handshake             Payload
// s         in   i_s_tvalid/o_s_tready  i_s_tdata (frame), i_s_tuser (mode)
// m         out  o_m_tvalid/i_m_tready  o_m_tdata (result), o_m_tuser (event)
// cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while the queue has room. A beat is decoded and queued in the cycle it
// arrives; the queue registers it, the back end applies it once its result register is free, and
// its result shows on m the cycle after that.
// The queue (QUEUE_DEPTH entries) absorbs stalls on m; s stalls when it fills.
// Synchronous active-low reset empties the queue, clears the packet state and resets the config registers.
// Top level of the reassembler; uses cpr_pkg, cpr_front, cpr_queue, cpr_back.
`default_nettype none

module can_packet_reassembler_unit #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int QUEUE_DEPTH      = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // frame_id[28:0], extended[29], dlc[33:30], data_0..data_7 [41:34]..[97:90]
    input  wire logic [103:0] i_s_tdata,
    // mode[0]
    input  wire logic         i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // write_offset[10:0], byte_count[13:11], payload_0..payload_6 [21:14]..[69:62],
    // packet_length[81:70], drop_total[113:82]
    output logic [119:0]      o_m_tdata,
    // event_res[2:0]
    output logic [2:0]        o_m_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [28:0]  i_cfg_data
);
    import cpr_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic [28:0]    r_host_id;
    logic [15:0]    r_timeout;
    t_cmd           w_cmd_in;
    t_cmd           w_cmd_out;
    logic [CMD_W-1:0] w_q_data;
    logic           w_q_full;
    logic           w_q_valid;
    logic           w_pop;
    t_result        w_res;
    t_back_status   w_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_id <= '0;
            r_timeout <= DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOST_ID: r_host_id <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                default:     r_host_id <= r_host_id;
            endcase
        end
    end

    cpr_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_mode     (i_s_tuser),
        .i_frame_id (i_s_tdata[28:0]),
        .i_extended (i_s_tdata[29]),
        .i_dlc      (i_s_tdata[33:30]),
        .i_data     (i_s_tdata[97:34]),
        .i_host_id  (r_host_id),
        .o_cmd      (w_cmd_in)
    );

    assign o_s_tready = !w_q_full;

    cpr_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_data  (w_cmd_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    assign w_cmd_out = t_cmd'(w_q_data);

    cpr_back #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_valid   (w_q_valid),
        .i_cmd     (w_cmd_out),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (w_res),
        .o_status  (w_st)
    );

    assign o_m_tuser = w_res.ev;
    assign o_m_tdata = {6'd0, w_res.drops, w_res.pkt_len, w_res.pay, w_res.cnt, w_res.offset};

`ifndef SYNTHESIS
    // a loaded result is on the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.load |=> o_m_tvalid)
        else $error("result not presented after load");

    // drop counter steps by one exactly on drop and timeout results
    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.load |=> (((w_res.ev == EV_DROP) || (w_res.ev == EV_TIMEOUT))
            ? (w_res.drops == $past(w_st.drop_cnt) + 32'd1)
            : (w_res.drops == $past(w_st.drop_cnt))))
        else $error("drop counter out of step with events");

    // completion and timeout leave no packet in progress
    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.load |=> (!((w_res.ev == EV_COMPLETE) || (w_res.ev == EV_TIMEOUT))
            || !w_st.busy))
        else $error("packet still in progress after completion or timeout");
`endif

endmodule

`default_nettype wire
